@@ rtl/core/pdc_pkg.sv @@
// Shared types, constants and digit decoding for the press duration counter.
package pdc_pkg;

  localparam int unsigned NUM_DIGITS    = 4;
  localparam int unsigned SHOWN_DIGITS  = 4;
  localparam int unsigned COUNT_W       = 14;
  localparam int unsigned SEG_W         = 8;
  localparam int unsigned KEY_W         = 4;
  localparam int unsigned TICK_W        = 8;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned APB_ADDR_W    = 3;

  localparam logic [KEY_W-1:0]      SWITCH_CODE  = 4'hE;
  localparam logic [TICK_W-1:0]     THRESH_RESET = 8'd150;
  localparam logic [APB_ADDR_W-3:0] REG_LONG_PRESS = 1'b0;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic step;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_value;
    logic [SEG_W-1:0]   seg_thousands;
    logic [SEG_W-1:0]   seg_hundreds;
    logic [SEG_W-1:0]   seg_tens;
    logic [SEG_W-1:0]   seg_units;
    logic               long_hold;
  } result_t;

  function automatic digit_t digit_clip(input digit_t d);
    digit_clip = (d <= 4'd9) ? d : 4'd0;
  endfunction

  function automatic logic [SEG_W-1:0] seg_pattern(input digit_t d);
    logic [SEG_W-1:0] p;
    unique case (d)
      4'd0:    p = 8'hE7;
      4'd1:    p = 8'h21;
      4'd2:    p = 8'hCB;
      4'd3:    p = 8'h6B;
      4'd4:    p = 8'h2D;
      4'd5:    p = 8'h6E;
      4'd6:    p = 8'hEE;
      4'd7:    p = 8'h23;
      4'd8:    p = 8'hEF;
      4'd9:    p = 8'h6F;
      default: p = 8'hE7;
    endcase
    seg_pattern = p;
  endfunction

endpackage

@@ rtl/core/press_duration_counter_ssd.sv @@
// Top level of the press duration counter with seven-segment digit patterns.
// Each key-line word yields exactly one result word, registered on acceptance; a
// new key word is accepted on every cycle in which the skid entry is empty. The
// digit cells form a ripple chain that increments, clears or holds the counter in
// the same cycle as the hold timer update, and a two-entry output register with a
// skid stage lets the input take one more word after the output starts to stall.
module press_duration_counter_ssd (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pdc_pkg::KEY_W-1:0]           in_key_lines,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pdc_pkg::COUNT_W-1:0]         out_count_value,
  output logic [pdc_pkg::SEG_W-1:0]           out_seg_thousands,
  output logic [pdc_pkg::SEG_W-1:0]           out_seg_hundreds,
  output logic [pdc_pkg::SEG_W-1:0]           out_seg_tens,
  output logic [pdc_pkg::SEG_W-1:0]           out_seg_units,
  output logic                                out_long_hold,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pdc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [pdc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [pdc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import pdc_pkg::*;

  logic [TICK_W-1:0] thr_r;
  logic [TICK_W-1:0] hold_r;
  logic [TICK_W-1:0] hold_nxt;
  logic              reg_hit;
  logic              cfg_wr;
  logic              in_accept;
  logic              out_take;
  logic              pressed;
  logic              inc;
  logic              clr;
  logic              long_nxt;
  cell_ctrl_t        ctrl;
  logic [NUM_DIGITS:0] carry;
  digit_t            digit_nxt [NUM_DIGITS];
  digit_t            shown [SHOWN_DIGITS];
  logic [COUNT_W-1:0] count_nxt;
  result_t           res_nxt;
  result_t           out_res_r;
  result_t           skid_res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_LONG_PRESS);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? {{(APB_DATA_W-TICK_W){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (cfg_wr) begin
      thr_r <= pwdata[TICK_W-1:0];
    end
  end

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;
  assign pressed   = (in_key_lines == SWITCH_CODE);

  always_comb begin
    inc = 1'b0;
    clr = 1'b0;
    if (pressed) begin
      hold_nxt = (hold_r < thr_r) ? TICK_W'(hold_r + 8'd1) : hold_r;
      clr      = (hold_nxt >= thr_r);
    end else begin
      inc      = (hold_r != '0) && (hold_r < thr_r);
      hold_nxt = '0;
    end
    long_nxt = (hold_nxt >= thr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (in_accept) begin
      hold_r <= hold_nxt;
    end
  end

  assign ctrl.step = in_accept;
  assign ctrl.clr  = clr;
  assign carry[0]  = inc;

  for (genvar gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
    pdc_digit_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .carry_in  (carry[gi]),
      .carry_out (carry[gi+1]),
      .digit_nxt (digit_nxt[gi])
    );
  end

  for (genvar gp = 0; gp < SHOWN_DIGITS; gp++) begin : g_shown
    if (gp < NUM_DIGITS) begin : g_real
      assign shown[gp] = digit_clip(digit_nxt[gp]);
    end else begin : g_blank
      assign shown[gp] = 4'd0;
    end
  end

  always_comb begin
    count_nxt = '0;
    for (int p = SHOWN_DIGITS - 1; p >= 0; p--) begin
      count_nxt = COUNT_W'(count_nxt * 14'd10) + COUNT_W'(shown[p]);
    end
  end

  assign res_nxt.count_value   = count_nxt;
  assign res_nxt.seg_thousands = seg_pattern(shown[3]);
  assign res_nxt.seg_hundreds  = seg_pattern(shown[2]);
  assign res_nxt.seg_tens      = seg_pattern(shown[1]);
  assign res_nxt.seg_units     = seg_pattern(shown[0]);
  assign res_nxt.long_hold     = long_nxt;

  always_comb begin
    if (out_take) begin
      out_valid_nxt  = skid_valid_r | in_accept;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt  = out_valid_r | in_accept;
      skid_valid_nxt = skid_valid_r | (in_accept & out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end else if (in_accept && (out_take || !out_valid_r)) begin
      out_res_r <= res_nxt;
    end
    if (in_accept && out_valid_r && !out_take) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_count_value   = out_res_r.count_value;
  assign out_seg_thousands = out_res_r.seg_thousands;
  assign out_seg_hundreds  = out_res_r.seg_hundreds;
  assign out_seg_tens      = out_res_r.seg_tens;
  assign out_seg_units     = out_res_r.seg_units;
  assign out_long_hold     = out_res_r.long_hold;

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a main output entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("word accepted behind a stalled output was not kept");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.count_value <= 14'd9999))
    else $error("count value out of decimal range");

  a_hold_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && pressed && (hold_r < thr_r)) |=> (hold_r == $past(hold_r) + 8'd1))
    else $error("hold timer failed to advance during a press");
`endif

endmodule

@@ rtl/core/pdc_digit_cell.sv @@
// One decimal digit of the counter, with carry in from the lower digit and carry out.
module pdc_digit_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pdc_pkg::cell_ctrl_t ctrl,
  input  logic               carry_in,
  output logic               carry_out,
  output pdc_pkg::digit_t    digit_nxt
);
  import pdc_pkg::*;

  digit_t digit_r;
  logic   wrap;

  assign wrap      = (digit_r >= 4'd9);
  assign carry_out = carry_in & wrap;

  always_comb begin
    if (ctrl.clr) begin
      digit_nxt = 4'd0;
    end else if (carry_in) begin
      digit_nxt = wrap ? 4'd0 : digit_t'(digit_r + 4'd1);
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= 4'd0;
    end else if (ctrl.step) begin
      digit_r <= digit_nxt;
    end
  end

endmodule

@@ verif/pdc_result_checker.sv @@
// Checker that predicts every result word of the press duration counter and compares it; it also checks register reads.
module pdc_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [pdc_pkg::KEY_W-1:0]      in_key_lines,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [pdc_pkg::COUNT_W-1:0]    out_count_value,
  input  logic [pdc_pkg::SEG_W-1:0]      out_seg_thousands,
  input  logic [pdc_pkg::SEG_W-1:0]      out_seg_hundreds,
  input  logic [pdc_pkg::SEG_W-1:0]      out_seg_tens,
  input  logic [pdc_pkg::SEG_W-1:0]      out_seg_units,
  input  logic                           out_long_hold,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pdc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pdc_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [pdc_pkg::APB_DATA_W-1:0] prdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending
);
  import pdc_pkg::*;

  logic [TICK_W-1:0] long_press_q;
  logic [TICK_W-1:0] hold_q;
  digit_t            tally [NUM_DIGITS];
  result_t           predicted_readouts [$];
  int                n_fail = 0;

  assign fail_count = n_fail;

  function automatic logic [SEG_W-1:0] segments_of(input digit_t d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd1:    s = 8'h21;
      4'd2:    s = 8'hCB;
      4'd3:    s = 8'h6B;
      4'd4:    s = 8'h2D;
      4'd5:    s = 8'h6E;
      4'd6:    s = 8'hEE;
      4'd7:    s = 8'h23;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'h6F;
      default: s = 8'hE7;
    endcase
    return s;
  endfunction

  function automatic result_t predict_tick(input logic [KEY_W-1:0] key);
    result_t     r;
    digit_t      shown [SHOWN_DIGITS];
    int unsigned val;
    bit          carry;
    int          d;
    if (key == SWITCH_CODE) begin
      if (hold_q < long_press_q) hold_q = hold_q + 1'b1;
      if (hold_q >= long_press_q) begin
        for (d = 0; d < NUM_DIGITS; d++) tally[d] = 4'd0;
      end
    end else begin
      if (hold_q != 0 && hold_q < long_press_q) begin
        carry = 1'b1;
        for (d = 0; d < NUM_DIGITS; d++) begin
          if (carry) begin
            if (tally[d] >= 4'd9) begin
              tally[d] = 4'd0;
            end else begin
              tally[d] = tally[d] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
      hold_q = '0;
    end
    val = 0;
    for (d = SHOWN_DIGITS - 1; d >= 0; d--) begin
      shown[d] = (d < NUM_DIGITS) ? tally[d] : 4'd0;
      val = val * 10 + shown[d];
    end
    r.count_value   = val[COUNT_W-1:0];
    r.seg_thousands = segments_of(shown[3]);
    r.seg_hundreds  = segments_of(shown[2]);
    r.seg_tens      = segments_of(shown[1]);
    r.seg_units     = segments_of(shown[0]);
    r.long_hold     = (hold_q >= long_press_q);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      long_press_q = THRESH_RESET;
      hold_q = '0;
      for (int d = 0; d < NUM_DIGITS; d++) tally[d] = 4'd0;
      predicted_readouts.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_LONG_PRESS)
        long_press_q = pwdata[TICK_W-1:0];
      if (in_valid && !in_stall) predicted_readouts.push_back(predict_tick(in_key_lines));
      if (out_valid && !out_stall) begin
        got.count_value   = out_count_value;
        got.seg_thousands = out_seg_thousands;
        got.seg_hundreds  = out_seg_hundreds;
        got.seg_tens      = out_seg_tens;
        got.seg_units     = out_seg_units;
        got.long_hold     = out_long_hold;
        if (predicted_readouts.size() == 0) begin
          note_failure($sformatf("unexpected result word count=%0d", got.count_value));
        end else begin
          want = predicted_readouts.pop_front();
          if (got !== want)
            note_failure($sformatf({"result mismatch: expected count=%0d seg=%h_%h_%h_%h ",
                                    "long=%b, got count=%0d seg=%h_%h_%h_%h long=%b"},
                                   want.count_value, want.seg_thousands, want.seg_hundreds,
                                   want.seg_tens, want.seg_units, want.long_hold,
                                   got.count_value, got.seg_thousands, got.seg_hundreds,
                                   got.seg_tens, got.seg_units, got.long_hold));
        end
      end
      if (psel && penable && !pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_LONG_PRESS &&
          prdata !== APB_DATA_W'(long_press_q))
        note_failure($sformatf("register read mismatch: expected %h, got %h",
                               APB_DATA_W'(long_press_q), prdata));
    end
    pending <= predicted_readouts.size();
  end

endmodule

@@ verif/tb_press_duration_counter_ssd.sv @@
// Testbench top for the press duration counter: stimulus, register set-up and verdict.
module tb_press_duration_counter_ssd;
  import pdc_pkg::*;

  localparam logic [APB_ADDR_W-1:0] THRESH_ADDR = {REG_LONG_PRESS, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KEY_W-1:0]      in_key_lines = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COUNT_W-1:0]    out_count_value;
  logic [SEG_W-1:0]      out_seg_thousands;
  logic [SEG_W-1:0]      out_seg_hundreds;
  logic [SEG_W-1:0]      out_seg_tens;
  logic [SEG_W-1:0]      out_seg_units;
  logic                  out_long_hold;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  bit idle_on = 1'b1;
  int cur_thresh = THRESH_RESET;

  press_duration_counter_ssd uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_key_lines(in_key_lines),
    .out_valid(out_valid), .out_stall(out_stall), .out_count_value(out_count_value),
    .out_seg_thousands(out_seg_thousands), .out_seg_hundreds(out_seg_hundreds),
    .out_seg_tens(out_seg_tens), .out_seg_units(out_seg_units),
    .out_long_hold(out_long_hold),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pdc_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_key_lines(in_key_lines),
    .out_valid(out_valid), .out_stall(out_stall), .out_count_value(out_count_value),
    .out_seg_thousands(out_seg_thousands), .out_seg_hundreds(out_seg_hundreds),
    .out_seg_tens(out_seg_tens), .out_seg_units(out_seg_units),
    .out_long_hold(out_long_hold),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) out_stall <= idle_on && ($urandom_range(0, 99) < 28);

  task automatic send_word(input logic [KEY_W-1:0] key);
    while (idle_on && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key_lines <= key;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_run(input int n, input logic [KEY_W-1:0] key);
    repeat (n) send_word(key);
  endtask

  function automatic logic [KEY_W-1:0] release_code();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom_range(0, 14));
    if (k == SWITCH_CODE) k = 4'hF;
    return k;
  endfunction

  // Stops the sender and waits until every predicted word has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= THRESH_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_threshold(input int value);
    drain();
    apb_access(1'b1, APB_DATA_W'(value));
    apb_access(1'b0, '0);
    cur_thresh = value;
  endtask

  task automatic random_phase(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_word(KEY_W'($urandom_range(0, 15)));
        sent++;
      end else begin
        len = $urandom_range(1, (cur_thresh < 20) ? cur_thresh + 2 : 20);
        send_run(len, SWITCH_CODE);
        sent += len;
        len = $urandom_range(1, 3);
        repeat (len) send_word(release_code());
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(4'h0);
    send_word(4'hF);
    send_word(SWITCH_CODE);
    send_word(4'hF);
    send_run(2, SWITCH_CODE);
    send_word(4'h0);
    for (int b = 0; b < KEY_W; b++) begin
      send_word(SWITCH_CODE);
      send_word(4'hF ^ (4'h1 << b));
    end
    send_word(4'h6);
    send_word(4'h9);

    set_threshold(1);
    send_run(2, SWITCH_CODE);
    send_word(4'hF);
    send_word(SWITCH_CODE);
    send_word(4'h0);

    set_threshold(255);
    send_run(3, SWITCH_CODE);
    send_word(4'hF);
    send_run(260, SWITCH_CODE);
    send_word(4'h5);

    // The timer keeps its count while the threshold is lowered beneath it.
    set_threshold(200);
    send_run(40, SWITCH_CODE);
    set_threshold(10);
    send_run(2, SWITCH_CODE);
    send_word(4'hF);
    set_threshold(200);
    send_run(40, SWITCH_CODE);
    set_threshold(10);
    send_word(4'hB);

    for (int p = 0; p < 5; p++) begin
      set_threshold((p == 1) ? 1 : (p == 3) ? 255 : $urandom_range(2, 12));
      idle_on = (p != 2);
      random_phase((p == 2) ? 60 : 30);
    end
    idle_on = 1'b1;

    set_threshold(THRESH_RESET);
    random_phase(20);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
